>>> rtl/mi_pkg.sv
// package for the modular inverse block
// holds the sequencer state type and the divider status struct
// no dependencies
package mi_pkg;

  // sequencer states of the top level
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_FINAL
  } mi_state_e;

  // status of the shared divide unit
  typedef struct packed {
    logic busy;
    logic done;
  } mi_div_stat_t;

endpackage

>>> rtl/mi_divider.sv
// shared bit-serial divide unit for one euclid step
// forms remainder of dividend / divisor and quotient times a multiplicand
// depends on mi_pkg
module mi_divider #(
  parameter int WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [WIDTH-1:0]       dividend_i,
  input  logic [WIDTH-1:0]       divisor_i,
  input  logic [WIDTH+1:0]       mcand_i,
  output mi_pkg::mi_div_stat_t   stat_o,
  output logic [WIDTH-1:0]       rem_o,
  output logic [WIDTH+1:0]       prod_o
);

  localparam int SW = WIDTH + 2;
  localparam int CW = $clog2(WIDTH + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [WIDTH-1:0] rem_q, rem_d;
  logic [WIDTH-1:0] dq_q, dq_d;
  logic [WIDTH-1:0] dvs_q, dvs_d;
  logic [SW-1:0]    mc_q, mc_d;
  logic [SW-1:0]    acc_q, acc_d;

  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   diff;
  logic             qbit;

  // one restoring step: shift in next dividend bit, compare and subtract
  assign trial = {rem_q, dq_q[WIDTH-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign qbit  = (trial >= {1'b0, dvs_q});

  // step sequencing and operand loading
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dq_d   = dq_q;
    dvs_d  = dvs_q;
    mc_d   = mc_q;
    acc_d  = acc_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(WIDTH);
      rem_d  = '0;
      dq_d   = dividend_i;
      dvs_d  = divisor_i;
      mc_d   = mcand_i;
      acc_d  = '0;
    end else if (busy_q) begin
      rem_d = qbit ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
      dq_d  = {dq_q[WIDTH-2:0], qbit};
      // quotient times multiplicand, msb first, wrapping at SW bits
      acc_d = {acc_q[SW-2:0], 1'b0} + (qbit ? mc_q : '0);
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dq_q  <= dq_d;
    dvs_q <= dvs_d;
    mc_q  <= mc_d;
    acc_q <= acc_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign rem_o       = rem_q;
  assign prod_o      = acc_q;

  // checks
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider started while busy");
  a_cnt_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != '0) else $error("divider busy with zero count");
  a_done_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_q) |-> ##(WIDTH+1) done_q) else $error("divider late");

endmodule

>>> rtl/modular_inverse.sv
// Modular inverse by the extended Euclidean algorithm. An item carries a
// value and a modulus; the result is the inverse of the value modulo the
// modulus in 0 to modulus-1, or no_inverse with inverse 0 when the gcd is
// not 1 or the modulus is 0. Items are worked one at a time: each Euclid
// step runs the shared bit-serial divider and then returns to the check
// state of the sequencer; the number of remainder steps is at most 46
// for 32 bits. in_stall_o is high while an item is in work; a finished
// result waits in the output register and does not block the next item
// from entering.
// depends on mi_pkg and mi_divider
module modular_inverse #(
  parameter int WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [WIDTH-1:0] value_i,
  input  logic [WIDTH-1:0] modulus_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [WIDTH-1:0] inverse_o,
  output logic             no_inverse_o
);

  localparam int SW = WIDTH + 2;

  mi_pkg::mi_state_e    state_q, state_d;
  mi_pkg::mi_div_stat_t div_stat;
  logic                 div_start;
  logic                 in_take;
  logic                 out_load;
  logic                 slot_free;

  logic [WIDTH-1:0] r0_q, r0_d, r1_q, r1_d, m_q, m_d;
  logic [SW-1:0]    s0_q, s0_d, s1_q, s1_d;
  logic [WIDTH-1:0] div_rem;
  logic [SW-1:0]    div_prod;

  logic             outv_q, outv_d;
  logic [WIDTH-1:0] inv_q, inv_d;
  logic             none_q, none_d;

  logic [SW-1:0]    m_ext;
  logic [SW-1:0]    fix;
  logic             res_none;
  logic [WIDTH-1:0] res_inv;

  assign in_take   = in_valid_i && !in_stall_o;
  assign slot_free = !outv_q || !out_stall_i;

  // shared divide unit
  mi_divider #(.WIDTH(WIDTH)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (r0_q),
    .divisor_i  (r1_q),
    .mcand_i    (s1_q),
    .stat_o     (div_stat),
    .rem_o      (div_rem),
    .prod_o     (div_prod)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mi_pkg::ST_IDLE:  if (in_valid_i) state_d = mi_pkg::ST_CHECK;
      mi_pkg::ST_CHECK: state_d = (r1_q == '0) ? mi_pkg::ST_FINAL : mi_pkg::ST_DIV;
      mi_pkg::ST_DIV:   if (div_stat.done) state_d = mi_pkg::ST_CHECK;
      mi_pkg::ST_FINAL: if (slot_free) state_d = mi_pkg::ST_IDLE;
      default:          state_d = mi_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall_o = (state_q != mi_pkg::ST_IDLE);
    div_start  = (state_q == mi_pkg::ST_CHECK) && (r1_q != '0);
    out_load   = (state_q == mi_pkg::ST_FINAL) && slot_free;
  end

  // remainder and coefficient registers
  always_comb begin
    r0_d = r0_q;
    r1_d = r1_q;
    s0_d = s0_q;
    s1_d = s1_q;
    m_d  = m_q;
    if (in_take) begin
      r0_d = value_i;
      r1_d = modulus_i;
      m_d  = modulus_i;
      s0_d = SW'(1);
      s1_d = '0;
    end else if ((state_q == mi_pkg::ST_DIV) && div_stat.done) begin
      r0_d = r1_q;
      r1_d = div_rem;
      s0_d = s1_q;
      s1_d = s0_q - div_prod;
    end
  end

  // normalise the coefficient into 0 to modulus-1
  assign m_ext = {2'b00, m_q};
  always_comb begin
    if (s0_q[SW-1]) begin
      fix = s0_q + m_ext;
    end else if (s0_q >= m_ext) begin
      fix = s0_q - m_ext;
    end else begin
      fix = s0_q;
    end
    res_none = (m_q == '0) || (r0_q != WIDTH'(1));
    res_inv  = res_none ? '0 : fix[WIDTH-1:0];
  end

  // output register
  always_comb begin
    outv_d = outv_q;
    inv_d  = inv_q;
    none_d = none_q;
    if (out_load) begin
      outv_d = 1'b1;
      inv_d  = res_inv;
      none_d = res_none;
    end else if (outv_q && !out_stall_i) begin
      outv_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mi_pkg::ST_IDLE;
      outv_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      outv_q  <= outv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r0_q   <= r0_d;
    r1_q   <= r1_d;
    s0_q   <= s0_d;
    s1_q   <= s1_d;
    m_q    <= m_d;
    inv_q  <= inv_d;
    none_q <= none_d;
  end

  assign out_valid_o  = outv_q;
  assign inverse_o    = inv_q;
  assign no_inverse_o = none_q;

  // checks
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> state_q == mi_pkg::ST_DIV) else $error("stray divider done");
  a_inv_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && !res_none) |-> res_inv < m_q) else $error("inverse out of range");
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (outv_q && none_q) |-> inv_q == '0) else $error("no_inverse with nonzero inverse");

endmodule
